>>> rtl/hwb_pkg.sv
// Package: sizes, item codes and transfer structs for the harmonic waveshape builder.
`timescale 1ns / 1ps
package hwb_pkg;
  localparam int HARMONIC_COUNT = 32;
  localparam int POINT_COUNT    = 16;
  localparam int HW             = $clog2(HARMONIC_COUNT);
  localparam int PW             = $clog2(POINT_COUNT);
  localparam int TERM_AW        = HW + PW;
  localparam int TERM_DEPTH     = HARMONIC_COUNT * POINT_COUNT;
  localparam int DIV_W          = 32;
  localparam int DIV_CW         = $clog2(DIV_W);
  localparam int PEAK_FLOOR     = 1023;
  localparam int SUM_DIVISOR    = 100;
  localparam int SCALE_SHIFT    = 16;
  localparam int FACTOR_W       = 17;

  // ceil(2^38 / 100): exact floor divide by 100 for magnitudes up to 2^31
  localparam logic [31:0] SUM_RECIP       = 32'hA3D70A3E;
  localparam int          SUM_RECIP_SHIFT = 38;

  localparam logic [2:0] KIND_LOAD    = 3'd0;
  localparam logic [2:0] KIND_AMP     = 3'd1;
  localparam logic [2:0] KIND_OFFSET  = 3'd2;
  localparam logic [2:0] KIND_COMPUTE = 3'd3;
  localparam logic [2:0] KIND_CLEAR   = 3'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic [4:0]         harmonic_index;
    logic [3:0]         point_index;
    logic signed [15:0] value;
  } item_t;

  typedef struct packed {
    logic signed [10:0] sample;
    logic [3:0]         point_number;
    logic               last;
  } result_t;
endpackage

>>> rtl/harmonic_waveshape_builder_top.sv
// Top level: sequencer over the basis, term and wave memories.
//
// One item at a time. After reset, and after each clear item, the offsets
// are cleared and the term memory is zeroed in a pass over every address
// with busy high. A table word or offset item is written from the idle
// state; an amplitude item steps through a basis read, a multiply and a
// term write for each point. A compute item reads each term in a read and
// an accumulate state, then for each point's divide by 100 runs a reciprocal
// multiply and a write state, and at the end the 32-step divider for the
// final scale factor. Each result passes read, multiply and emit states,
// with strobe high for one cycle; the receiver cannot stall them.
`timescale 1ns / 1ps
module harmonic_waveshape_builder_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  hwb_pkg::item_t   item,
  output logic             strobe,
  output hwb_pkg::result_t result
);
  import hwb_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_CLR     = 13'b0000000000010,
    S_AMP_RD  = 13'b0000000000100,
    S_AMP_MUL = 13'b0000000001000,
    S_AMP_WR  = 13'b0000000010000,
    S_SUM_RD  = 13'b0000000100000,
    S_SUM_ACC = 13'b0000001000000,
    S_DIV_Q   = 13'b0000010000000,
    S_DIV_F   = 13'b0000100000000,
    S_OUT_RD  = 13'b0001000000000,
    S_OUT_MUL = 13'b0010000000000,
    S_OUT_EMIT= 13'b0100000000000,
    S_WAVE_WR = 13'b1000000000000
  } state_t;

  state_t                    state;
  logic [HW-1:0]             h_cnt;
  logic [PW-1:0]             p_cnt;
  logic [TERM_AW-1:0]        clr_cnt;
  logic signed [15:0]        amp;
  logic [31:0]               acc;
  logic                      neg;
  logic [31:0]               sum_mag;
  logic [63:0]               quot_prod;
  logic [31:0]               peak;
  logic [FACTOR_W-1:0]       factor;
  logic signed [49:0]        prod;
  logic [31:0]               term_prod;
  logic signed [15:0]        offsets [POINT_COUNT];

  logic                      accept;
  logic [15:0]               basis_rdata;
  logic [31:0]               term_rdata;
  logic [31:0]               wave_rdata;
  logic                      term_we;
  logic [TERM_AW-1:0]        term_waddr;
  logic [31:0]               term_wdata;
  logic                      wave_we;
  logic [31:0]               quot;
  logic [31:0]               wave_w;
  logic [31:0]               abs_w;
  logic [31:0]               acc_new;
  logic                      div_start;
  logic [DIV_W-1:0]          div_dividend;
  logic [DIV_W-1:0]          div_divisor;
  logic                      div_done;
  logic [DIV_W-1:0]          div_q;
  logic                      h_last;
  logic                      p_last;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign h_last  = (h_cnt == HW'(HARMONIC_COUNT - 1));
  assign p_last  = (p_cnt == PW'(POINT_COUNT - 1));
  assign acc_new = ((h_cnt == '0) ? 32'd0 : acc) + term_rdata;

  assign term_we    = (state == S_CLR) || (state == S_AMP_WR);
  assign term_waddr = (state == S_CLR) ? clr_cnt : {h_cnt, p_cnt};
  assign term_wdata = (state == S_CLR) ? 32'd0 : term_prod;

  assign quot    = 32'(quot_prod[63:SUM_RECIP_SHIFT]);
  assign wave_w  = (neg ? -quot : quot) + 32'($signed(offsets[p_cnt]));
  assign abs_w   = wave_w[31] ? -wave_w : wave_w;
  assign wave_we = (state == S_WAVE_WR);

  always_comb begin
    div_start    = wave_we && p_last;
    div_dividend = DIV_W'(PEAK_FLOOR) << SCALE_SHIFT;
    div_divisor  = (abs_w > peak) ? abs_w : peak;
  end

  hwb_ram #(.WIDTH(16), .DEPTH(TERM_DEPTH)) u_basis (
    .clk   (clk),
    .we    (accept && item.kind == KIND_LOAD),
    .waddr ({item.harmonic_index[HW-1:0], item.point_index[PW-1:0]}),
    .wdata (item.value),
    .raddr ({h_cnt, p_cnt}),
    .rdata (basis_rdata)
  );

  hwb_ram #(.WIDTH(32), .DEPTH(TERM_DEPTH)) u_terms (
    .clk   (clk),
    .we    (term_we),
    .waddr (term_waddr),
    .wdata (term_wdata),
    .raddr ({h_cnt, p_cnt}),
    .rdata (term_rdata)
  );

  hwb_ram #(.WIDTH(32), .DEPTH(POINT_COUNT)) u_wave (
    .clk   (clk),
    .we    (wave_we),
    .waddr (p_cnt),
    .wdata (wave_w),
    .raddr (p_cnt),
    .rdata (wave_rdata)
  );

  hwb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      strobe  <= 1'b0;
      h_cnt   <= '0;
      p_cnt   <= '0;
      for (int i = 0; i < POINT_COUNT; i++) begin
        offsets[i] <= '0;
      end
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.kind)
              KIND_AMP: begin
                h_cnt <= item.harmonic_index[HW-1:0];
                p_cnt <= '0;
                amp   <= item.value;
                state <= S_AMP_RD;
              end
              KIND_OFFSET: offsets[item.point_index[PW-1:0]] <= item.value;
              KIND_COMPUTE: begin
                h_cnt <= '0;
                p_cnt <= '0;
                peak  <= 32'(PEAK_FLOOR);
                state <= S_SUM_RD;
              end
              KIND_CLEAR: begin
                for (int i = 0; i < POINT_COUNT; i++) begin
                  offsets[i] <= '0;
                end
                clr_cnt <= '0;
                state   <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == TERM_AW'(TERM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_AMP_RD:  state <= S_AMP_MUL;
        S_AMP_MUL: begin
          term_prod <= 32'($signed(basis_rdata) * amp);
          state     <= S_AMP_WR;
        end
        S_AMP_WR: begin
          p_cnt <= p_cnt + 1'b1;
          state <= p_last ? S_IDLE : S_AMP_RD;
        end
        S_SUM_RD: state <= S_SUM_ACC;
        S_SUM_ACC: begin
          acc   <= acc_new;
          h_cnt <= h_cnt + 1'b1;
          if (h_last) begin
            neg     <= acc_new[31];
            sum_mag <= acc_new[31] ? -acc_new : acc_new;
            state   <= S_DIV_Q;
          end else begin
            state <= S_SUM_RD;
          end
        end
        S_DIV_Q: begin
          quot_prod <= {32'd0, sum_mag} * {32'd0, SUM_RECIP};
          state     <= S_WAVE_WR;
        end
        S_WAVE_WR: begin
          if (abs_w > peak) begin
            peak <= abs_w;
          end
          h_cnt <= '0;
          if (p_last) begin
            state <= S_DIV_F;
          end else begin
            p_cnt <= p_cnt + 1'b1;
            state <= S_SUM_RD;
          end
        end
        S_DIV_F: begin
          if (div_done) begin
            factor <= div_q[FACTOR_W-1:0];
            p_cnt  <= '0;
            state  <= S_OUT_RD;
          end
        end
        S_OUT_RD:  state <= S_OUT_MUL;
        S_OUT_MUL: begin
          prod  <= $signed(wave_rdata) * $signed({1'b0, factor});
          state <= S_OUT_EMIT;
        end
        S_OUT_EMIT: begin
          strobe              <= 1'b1;
          result.sample       <= prod[SCALE_SHIFT+10:SCALE_SHIFT];
          result.point_number <= 4'(p_cnt);
          result.last         <= p_last;
          p_cnt               <= p_cnt + 1'b1;
          state               <= p_last ? S_IDLE : S_OUT_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/hwb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hwb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/hwb_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module hwb_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [hwb_pkg::DIV_W-1:0] dividend,
  input  logic [hwb_pkg::DIV_W-1:0] divisor,
  output logic                     done,
  output logic [hwb_pkg::DIV_W-1:0] quotient
);
  import hwb_pkg::*;

  logic [DIV_W-1:0]  dq;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_CW-1:0] cnt;
  logic              run;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    diff;
  logic              ge;

  assign rem_sh   = {rem, dq[DIV_W-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign ge       = ~diff[DIV_W];
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dq  <= dividend;
        rem <= '0;
        dvs <= divisor;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        dq  <= {dq[DIV_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/hwb_checker.sv
// Port-level checker for the harmonic waveshape builder, bound to the top level.
`timescale 1ns / 1ps
module hwb_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input hwb_pkg::item_t   item,
  input logic             strobe,
  input hwb_pkg::result_t result
);
  import hwb_pkg::*;

  a_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.sample != 11'sh400))
    else $error("sample outside normalized range");

  a_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |-> (result.point_number == 4'(POINT_COUNT - 1)))
    else $error("last flag on wrong point");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("back-to-back result transfers");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> busy)
    else $error("no clearing pass after reset");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.kind == KIND_COMPUTE) |=> busy)
    else $error("compute transfer not taken");
endmodule

bind harmonic_waveshape_builder_top hwb_checker u_hwb_checker (.*);

>>> tb/tb.sv
// Testbench for harmonic_waveshape_builder_top: queued command driver, result monitor, predictor.
`timescale 1ns / 1ps
module tb;
  import hwb_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 2000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  logic    strobe;
  item_t   item = '0;
  result_t result;

  harmonic_waveshape_builder_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .strobe(strobe), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t   cmd_queue[$];
  bit      drain_first[$];
  result_t expected_samples[$];

  int accepted_cnt = 0;
  int issued_cnt = 0;
  int total_cmds = 0;
  int errors = 0;
  int samples_seen = 0;
  int waves_built = 0;
  int quiet_cycles = 0;

  // predictor state
  logic signed [15:0] basis_mem [HARMONIC_COUNT][POINT_COUNT];
  logic [31:0]        term_mem [HARMONIC_COUNT][POINT_COUNT];
  logic signed [15:0] offset_mem [POINT_COUNT];

  // generator-side record of which basis words are written
  logic [POINT_COUNT-1:0] row_written [HARMONIC_COUNT];

  function automatic void build_wave();
    int          wave [POINT_COUNT];
    int          peak;
    int          mag;
    logic [31:0] acc;
    longint      factor;
    longint      prod;
    result_t     r;
    peak = PEAK_FLOOR;
    for (int p = 0; p < POINT_COUNT; p++) begin
      acc = '0;
      for (int h = 0; h < HARMONIC_COUNT; h++) acc += term_mem[h][p];
      wave[p] = $signed(acc) / SUM_DIVISOR + int'(offset_mem[p]);
      mag = (wave[p] < 0) ? -wave[p] : wave[p];
      if (mag > peak) peak = mag;
    end
    factor = (longint'(PEAK_FLOOR) <<< SCALE_SHIFT) / peak;
    for (int p = 0; p < POINT_COUNT; p++) begin
      prod = longint'(wave[p]) * factor;
      prod = prod >>> SCALE_SHIFT;
      r.sample = prod[10:0];
      r.point_number = p[3:0];
      r.last = (p == POINT_COUNT - 1);
      expected_samples.push_back(r);
    end
    waves_built++;
  endfunction

  function automatic void predict(item_t it);
    case (it.kind)
      KIND_LOAD: basis_mem[it.harmonic_index][it.point_index] = it.value;
      KIND_AMP: begin
        for (int p = 0; p < POINT_COUNT; p++)
          term_mem[it.harmonic_index][p] =
            32'(int'(basis_mem[it.harmonic_index][p]) * int'(it.value));
      end
      KIND_OFFSET: offset_mem[it.point_index] = it.value;
      KIND_CLEAR: begin
        for (int h = 0; h < HARMONIC_COUNT; h++) begin
          for (int p = 0; p < POINT_COUNT; p++) term_mem[h][p] = '0;
        end
        for (int p = 0; p < POINT_COUNT; p++) offset_mem[p] = '0;
      end
      KIND_COMPUTE: build_wave();
      default: ;
    endcase
  endfunction

  function automatic void add_cmd(logic [2:0] k, int h, int p, logic [15:0] v, bit drain = 0);
    item_t it;
    it.kind = k;
    it.harmonic_index = h[4:0];
    it.point_index = p[3:0];
    it.value = v;
    if (k == KIND_LOAD) row_written[h][p] = 1'b1;
    cmd_queue.push_back(it);
    drain_first.push_back(drain);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int idle_pct();
    if (issued_cnt < total_cmds / 3) return 14;
    if (issued_cnt < 2 * total_cmds / 3) return 59;
    return 0;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || accepted_cnt == issued_cnt) begin
      if (cmd_queue.size() > 0 && !(drain_first[0] && expected_samples.size() != 0) &&
          $urandom_range(99) >= idle_pct()) begin
        item <= cmd_queue.pop_front();
        drain_first.delete(0);
        start <= 1'b1;
        issued_cnt++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (start && !busy) begin
        predict(item);
        accepted_cnt++;
      end
      if (strobe) begin
        samples_seen++;
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (result.sample !== want.sample || result.point_number !== want.point_number ||
              result.last !== want.last) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, result);
            errors++;
          end
        end
      end
      if ((start && !busy) || strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL harmonic_waveshape_builder_top");
        $finish;
      end
    end
  end

  initial begin
    int h;
    int sel;
    for (int i = 0; i < HARMONIC_COUNT; i++) begin
      row_written[i] = '0;
      for (int p = 0; p < POINT_COUNT; p++) term_mem[i][p] = '0;
    end
    for (int p = 0; p < POINT_COUNT; p++) offset_mem[p] = '0;

    // directed part
    add_cmd(KIND_COMPUTE, 0, 0, 16'h0);
    add_cmd(3'd5, 31, 15, 16'hffff);
    add_cmd(3'd6, 0, 0, 16'h0);
    add_cmd(3'd7, 21, 10, 16'h5555);
    add_cmd(KIND_OFFSET, 0, 0, 16'h7fff);
    add_cmd(KIND_OFFSET, 0, 15, 16'h8000);
    add_cmd(KIND_COMPUTE, 0, 0, 16'h0, 1'b1);
    add_cmd(KIND_OFFSET, 0, 7, 16'd1023);
    add_cmd(KIND_OFFSET, 0, 0, 16'hfc01);
    add_cmd(KIND_OFFSET, 0, 15, 16'd500);
    add_cmd(KIND_COMPUTE, 0, 0, 16'h0);
    add_cmd(KIND_LOAD, 31, 15, 16'h8000);
    add_cmd(KIND_LOAD, 0, 0, 16'h7fff);
    add_cmd(KIND_CLEAR, 0, 0, 16'h0);
    add_cmd(KIND_COMPUTE, 0, 0, 16'h0);

    // random part: mostly full basis rows followed by amplitudes and computes
    while (cmd_queue.size() < 410) begin
      sel = $urandom_range(99);
      if (sel < 20) begin
        h = $urandom_range(31);
        for (int p = 0; p < POINT_COUNT; p++) add_cmd(KIND_LOAD, h, p, rand_word());
        add_cmd(KIND_AMP, h, $urandom_range(15), rand_word());
      end else if (sel < 45) begin
        h = $urandom_range(31);
        if (row_written[h] == '1) add_cmd(KIND_AMP, h, $urandom_range(15), rand_word());
        else add_cmd(KIND_LOAD, h, $urandom_range(15), rand_word());
      end else if (sel < 62) begin
        add_cmd(KIND_OFFSET, $urandom_range(31), $urandom_range(15), rand_word());
      end else if (sel < 80) begin
        add_cmd(KIND_COMPUTE, $urandom_range(31), $urandom_range(15), 16'($urandom),
                cmd_queue.size() > 200 && cmd_queue.size() < 215);
      end else if (sel < 84) begin
        add_cmd(KIND_CLEAR, $urandom_range(31), $urandom_range(15), 16'($urandom));
      end else if (sel < 89) begin
        add_cmd(3'($urandom_range(7, 5)), $urandom_range(31), $urandom_range(15),
                16'($urandom));
      end else begin
        add_cmd(KIND_LOAD, $urandom_range(31), $urandom_range(15), rand_word());
      end
    end
    add_cmd(KIND_COMPUTE, 0, 0, 16'h0);
    total_cmds = cmd_queue.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (accepted_cnt == total_cmds && expected_samples.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run: %0d commands transferred, %0d waveshapes built, %0d samples checked,",
             accepted_cnt, waves_built, samples_seen);
    $display("  %0d mismatches over three sender pacing phases.", errors);
    if (errors == 0) begin
      $display("PASS harmonic_waveshape_builder_top");
    end else begin
      $display("FAIL harmonic_waveshape_builder_top");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/hwb_pkg.sv
rtl/hwb_ram.sv
rtl/hwb_div.sv
rtl/harmonic_waveshape_builder_top.sv
rtl/hwb_checker.sv
tb/tb.sv
